/* src/ibct_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the booking table.
package ibct_pkg;

  localparam int MAX_INTERVALS = 64;
  localparam int TIME_BITS     = 31;
  localparam int IDX_BITS      = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CNT_BITS      = 7;
  localparam int ENTRY_BITS    = 2 * TIME_BITS;
  localparam int STATUS_BITS   = 2;

  localparam int IN_DATA_BITS  = ((ENTRY_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS  = STATUS_BITS + CNT_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_BOOKED  = 2'd0,
    STATUS_OVERLAP = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;    // latch request, restart scan
    logic    scan;    // issue read of next stored entry
    logic    append;  // write request at fill slot, bump count
    logic    emit;    // load result register
    status_t status;
  } ibct_cmd_t;

  typedef struct packed {
    logic empty_req;  // request holds no time
    logic hit;        // entry read last cycle overlaps request
    logic scan_end;   // every stored entry has been read
    logic rd_pending; // a read is still in flight
    logic full;
    logic out_free;
  } ibct_sts_t;

endpackage

/* src/ibct_dp.sv */
// Datapath: request registers, interval memory, scan counter, overlap compare, result register.
module ibct_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  ibct_pkg::ibct_cmd_t                cmd,
  output ibct_pkg::ibct_sts_t                sts,
  input  logic [ibct_pkg::IN_DATA_BITS-1:0]  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ibct_pkg::OUT_DATA_BITS-1:0] out_data
);
  import ibct_pkg::*;

  logic [ENTRY_BITS-1:0] mem [MAX_INTERVALS];
  logic [ENTRY_BITS-1:0] rd_data;
  logic                  rd_vld;
  logic [TIME_BITS-1:0]  req_lo;
  logic [TIME_BITS-1:0]  req_hi;
  logic [CNT_BITS-1:0]   fill_count;
  logic [CNT_BITS-1:0]   idx;
  status_t               res_status;
  logic [CNT_BITS-1:0]   res_count;
  logic [TIME_BITS-1:0]  ent_lo;
  logic [TIME_BITS-1:0]  ent_hi;
  logic                  do_read;

  assign ent_lo  = rd_data[TIME_BITS-1:0];
  assign ent_hi  = rd_data[ENTRY_BITS-1:TIME_BITS];
  assign do_read = cmd.scan && (idx != fill_count);

  assign sts.empty_req  = (req_hi <= req_lo);
  assign sts.hit        = rd_vld && (ent_lo < req_hi) && (req_lo < ent_hi);
  assign sts.scan_end   = (idx == fill_count);
  assign sts.rd_pending = rd_vld;
  assign sts.full       = (fill_count == CNT_BITS'(MAX_INTERVALS));
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[fill_count[IDX_BITS-1:0]] <= {req_hi, req_lo};
    end
    if (do_read) begin
      rd_data <= mem[idx[IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_lo <= in_data[TIME_BITS-1:0];
      req_hi <= in_data[ENTRY_BITS-1:TIME_BITS];
    end
    if (cmd.emit) begin
      res_status <= cmd.status;
      res_count  <= fill_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      idx        <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_vld <= do_read;
      if (cmd.load) begin
        idx <= '0;
      end else if (do_read) begin
        idx <= idx + CNT_BITS'(1);
      end
      if (cmd.append) begin
        fill_count <= fill_count + CNT_BITS'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_data = {{(OUT_DATA_BITS - OUT_RAW_BITS){1'b0}}, res_count, res_status};

endmodule

/* src/ibct_ctrl.sv */
// Controller: sequences request latch, table scan, append decision and result hand-off.
module ibct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ibct_pkg::ibct_sts_t sts,
  output ibct_pkg::ibct_cmd_t cmd
);
  import ibct_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DECIDE,
    DONE
  } state_t;

  state_t  state;
  status_t status;

  assign in_ready   = (state == IDLE);
  assign cmd.load   = in_valid && (state == IDLE);
  assign cmd.scan   = (state == SCAN);
  assign cmd.append = (state == DECIDE) && !sts.full;
  assign cmd.emit   = (state == DONE) && sts.out_free;
  assign cmd.status = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      status <= STATUS_BOOKED;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (sts.empty_req) begin
            status <= STATUS_BOOKED;
            state  <= DONE;
          end else if (sts.hit) begin
            status <= STATUS_OVERLAP;
            state  <= DONE;
          end else if (sts.scan_end && !sts.rd_pending) begin
            state <= DECIDE;
          end
        end
        DECIDE: begin
          status <= sts.full ? STATUS_FULL : STATUS_BOOKED;
          state  <= DONE;
        end
        DONE: begin
          if (sts.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* src/interval_booking_conflict_table_unit.sv */
// Top level of the interval booking table: controller plus datapath.
//
//  channel   dir  width  contents
//  s_axis    in   64     start_time[30:0], end_time[61:31]
//  m_axis    out  16     status[1:0], entries_held[8:2]
//
// The time from acceptance to result grows with fill_count, set by the
// one-entry-per-cycle scan through the interval memory's single read port;
// an overlap or an empty request ends the scan early.
// One item is in work at a time; the next is accepted once the result sits in the
// output register. A stalled m_axis holds the result and blocks only the hand-off.
// Reset empties the table at once; memory contents are never cleared.
module interval_booking_conflict_table_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [30:0] start_time, [61:31] end_time, [63:62] zero
  input  logic [ibct_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] status, [8:2] entries_held, [15:9] zero
  output logic [ibct_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
  import ibct_pkg::*;

  ibct_cmd_t cmd;
  ibct_sts_t sts;

  ibct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ibct_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

/* src/ibct_checker.sv */
// Port-level checks for the interval booking table, bound to the top level.
module ibct_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [ibct_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
  import ibct_pkg::*;

  logic [STATUS_BITS-1:0] out_status;
  logic [CNT_BITS-1:0]    out_count;

  assign out_status = m_axis_tdata[STATUS_BITS-1:0];
  assign out_count  = m_axis_tdata[OUT_RAW_BITS-1:STATUS_BITS];

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled item changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_status == STATUS_BOOKED) || (out_status == STATUS_OVERLAP) ||
                      (out_status == STATUS_FULL))
    else $error("undefined status code");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_count <= CNT_BITS'(MAX_INTERVALS))
    else $error("entry count beyond table size");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_status == STATUS_FULL) |-> out_count == CNT_BITS'(MAX_INTERVALS))
    else $error("full status with room left");

endmodule

bind interval_booking_conflict_table_unit ibct_checker u_ibct_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* test/tb_top.sv */
// Self-checking testbench for the interval booking table: directed and random requests.
module tb_top;
  import ibct_pkg::*;

  localparam longint TIME_MAX     = (64'd1 << TIME_BITS) - 1;
  localparam int     RANDOM_ITEMS = 1030;
  localparam int     QUIET_TAIL   = 150;
  localparam int     DRAIN_CYCLES = MAX_INTERVALS + 16;

  typedef struct {
    status_t             status;
    logic [CNT_BITS-1:0] held;
  } booking_result_t;

  // Mirror of the table; also used to aim requests at stored intervals.
  class booking_scoreboard;
    logic [TIME_BITS-1:0] interval_lo [MAX_INTERVALS];
    logic [TIME_BITS-1:0] interval_hi [MAX_INTERVALS];
    int unsigned          held;
    int unsigned          errors;
    booking_result_t      expected_q [$];

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function void note_request(input logic [TIME_BITS-1:0] lo, input logic [TIME_BITS-1:0] hi);
      booking_result_t      want;
      logic [TIME_BITS-1:0] top_lo;
      logic [TIME_BITS-1:0] low_hi;
      want.status = STATUS_BOOKED;
      // an empty request never collides and is never stored
      if (hi > lo) begin
        for (int i = 0; i < held; i++) begin
          top_lo = (interval_lo[i] > lo) ? interval_lo[i] : lo;
          low_hi = (interval_hi[i] < hi) ? interval_hi[i] : hi;
          if (top_lo < low_hi) begin
            want.status = STATUS_OVERLAP;
            break;
          end
        end
        if (want.status == STATUS_BOOKED) begin
          if (held >= MAX_INTERVALS) begin
            want.status = STATUS_FULL;
          end else begin
            interval_lo[held] = lo;
            interval_hi[held] = hi;
            held++;
          end
        end
      end
      want.held = held[CNT_BITS-1:0];
      expected_q.insert(expected_q.size(), want);
    endfunction

    function void check_result(input logic [OUT_DATA_BITS-1:0] data);
      booking_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result item %h", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (data[STATUS_BITS-1:0] !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, data[STATUS_BITS-1:0]);
        errors++;
      end
      if (data[STATUS_BITS+CNT_BITS-1:STATUS_BITS] !== want.held) begin
        $error("entries_held: expected %0d, actual %0d", want.held,
               data[STATUS_BITS+CNT_BITS-1:STATUS_BITS]);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  booking_scoreboard sb;
  bit                gaps_on    = 1'b1;
  int                stall_left = 0;

  interval_booking_conflict_table_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: check accepted items, stall in short bursts
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_request(input logic [TIME_BITS-1:0] lo, input logic [TIME_BITS-1:0] hi);
    logic [IN_DATA_BITS-1:0] word;
    word = '0;
    word[TIME_BITS-1:0] = lo;
    word[2*TIME_BITS-1:TIME_BITS] = hi;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(lo, hi);
  endtask

  // Mostly small intervals aimed at or next to stored ones, plus empties and wide noise.
  task automatic pick_random_request(output logic [TIME_BITS-1:0] lo,
                                     output logic [TIME_BITS-1:0] hi);
    int unsigned kind;
    int unsigned k;
    longint      a;
    longint      b;
    longint      s;
    longint      e;
    longint      len;
    kind = $urandom_range(0, 99);
    len  = $urandom_range(1, 3000);
    a    = $urandom_range(0, TIME_MAX - len);
    b    = a + len;
    if (sb.held > 0) begin
      k = $urandom_range(0, sb.held - 1);
      s = sb.interval_lo[k];
      e = sb.interval_hi[k];
    end else begin
      s = a;
      e = b;
    end
    if (kind < 15) begin
      // fresh interval somewhere in the time range
    end else if (kind < 25) begin
      // touching a stored interval on one side
      if (kind[0]) begin
        a = e;
        b = e + len;
      end else begin
        a = s - len;
        b = s;
      end
    end else if (kind < 60) begin
      case (kind % 5)
        0: begin a = s; b = e; end
        1: begin a = s - $urandom_range(0, 50); b = e + $urandom_range(0, 50); end
        2: begin a = $urandom_range(s, e - 1); b = $urandom_range(a + 1, e); end
        3: begin a = s - len; b = $urandom_range(s + 1, e); end
        default: begin a = $urandom_range(s, e - 1); b = e + len; end
      endcase
    end else if (kind < 78) begin
      b = (kind < 66) ? a : $urandom_range(0, a);
    end else if (kind < 90) begin
      a = $urandom_range(0, TIME_MAX);
      b = $urandom_range(0, TIME_MAX);
    end else begin
      case ($urandom_range(0, 2))
        0:       a = 0;
        1:       a = TIME_MAX;
        default: a = $urandom_range(0, TIME_MAX);
      endcase
      case ($urandom_range(0, 3))
        0:       b = 0;
        1:       b = 1;
        2:       b = TIME_MAX - 1;
        default: b = TIME_MAX;
      endcase
    end
    if (a < 0) a = 0;
    if (a > TIME_MAX) a = TIME_MAX;
    if (b < 0) b = 0;
    if (b > TIME_MAX) b = TIME_MAX;
    lo = a[TIME_BITS-1:0];
    hi = b[TIME_BITS-1:0];
  endtask

  initial begin
    logic [TIME_BITS-1:0] lo;
    logic [TIME_BITS-1:0] hi;
    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty requests, mostly at the edges of the range
    send_request(31'd0, 31'd0);
    send_request(31'h7FFFFFFF, 31'h7FFFFFFF);
    send_request(31'h7FFFFFFF, 31'd0);
    send_request(31'd5, 31'd3);
    // bookings at both ends, then overlaps and touching neighbors
    send_request(31'd0, 31'd1);
    send_request(31'h7FFFFFFE, 31'h7FFFFFFF);
    send_request(31'd0, 31'd1);
    send_request(31'd1, 31'd100);
    send_request(31'd50, 31'd60);
    send_request(31'd99, 31'd200);
    send_request(31'd200, 31'd300);
    send_request(31'd150, 31'd250);
    send_request(31'd0, 31'h7FFFFFFF);
    send_request(31'd300, 31'd300);
    send_request(31'h2AAAAAAA, 31'h55555555);
    send_request(31'h55555554, 31'h55555556);
    send_request(31'h7FFFFFFE, 31'h7FFFFFFF);
    send_request(31'd300, 31'h2AAAAAAA);
    send_request(31'h55555555, 31'h7FFFFFFE);
    send_request(31'h12345678, 31'h12345677);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_TAIL) gaps_on = 1'b0;
      pick_random_request(lo, hi);
      send_request(lo, hi);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ibct_pkg.sv
src/ibct_dp.sv
src/ibct_ctrl.sv
src/interval_booking_conflict_table_unit.sv
src/ibct_checker.sv
test/tb_top.sv
